// ===== src/csan_pkg.sv =====
// Shared constants and arithmetic helpers for the color sensor averaging block.
`default_nettype none

package csan_pkg;

  localparam int NUM_CH       = 4;
  localparam int NUM_COLOR    = 3;
  localparam int CH_W         = 2;
  // Window depth must stay a power of two: the mean is taken by a shift.
  localparam int WINDOW_DEPTH = 16;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int ADDR_W       = CH_W + PTR_W;
  localparam int MEM_DEPTH    = NUM_CH * WINDOW_DEPTH;

  localparam int PULSE_W      = 20;
  localparam int LEVEL_W      = 9;
  localparam int SUM_W        = LEVEL_W + PTR_W;
  localparam int NORM_W       = 16;
  localparam int DRIVE_W      = 8;
  localparam int GAP_W        = 15;
  localparam int CNT_W        = $clog2(NORM_W);

  localparam int IN_DATA_W    = NUM_CH * PULSE_W;
  localparam int OUT_USED_W   = NUM_COLOR * NORM_W + LEVEL_W + NUM_COLOR * DRIVE_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [9:0]          PULSE_CLAMP = 10'd1000;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 9'd257;
  localparam logic [NORM_W-1:0]   NORM_MAX    = 16'hFFFF;
  localparam logic [DRIVE_W-1:0]  DRIVE_MAX   = 8'hFF;
  localparam logic [GAP_W-1:0]    LEVEL_DIV   = 15'd66;
  localparam logic [31:0]         DRIVE_SAT   = 32'd65280;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [NORM_W-1:0]  norm_t;
  typedef logic [DRIVE_W-1:0] drive_t;
  typedef logic [GAP_W-1:0]   gap_t;

  // (1000 - min(p, 1000)) * 17; the level is this value divided by 66.
  function automatic gap_t scaled_gap(input logic [PULSE_W-1:0] p);
    logic [9:0] pc;
    logic [9:0] d;
    pc = (p > {10'd0, PULSE_CLAMP}) ? PULSE_CLAMP : p[9:0];
    d  = PULSE_CLAMP - pc;
    return {1'b0, d, 4'd0} + {5'd0, d};
  endfunction

  // Reciprocal estimate of y / 66 using 992 / 65536; low by at most one.
  function automatic level_t level_est(input gap_t y);
    logic [24:0] prod;
    prod = {y, 10'd0} - {5'd0, y, 5'd0};
    return prod[24:16];
  endfunction

  function automatic level_t level_fix(input gap_t y, input level_t qe);
    gap_t m;
    gap_t r;
    m = {qe[8:0], 6'd0} + {5'd0, qe, 1'b0};
    r = y - m;
    return qe + ((r >= LEVEL_DIV) ? 9'd1 : 9'd0);
  endfunction

  function automatic norm_t times255(input level_t m);
    logic [16:0] p;
    p = {m, 8'd0} - {8'd0, m};
    return p[15:0];
  endfunction

  // floor(n*n / 255) saturated at 255, from the registered square.
  function automatic drive_t drive_of(input logic [31:0] prod);
    logic [15:0] x;
    logic [16:0] s;
    logic [8:0]  q0;
    logic [16:0] m;
    logic [16:0] r;
    logic [8:0]  q;
    x  = prod[15:0];
    s  = {1'b0, x} + {9'd0, x[15:8]};
    q0 = s[16:8];
    m  = {q0, 8'd0} - {8'd0, q0};
    r  = {1'b0, x} - m;
    q  = q0 + ((r >= 17'd255) ? 9'd1 : 9'd0);
    return (prod >= DRIVE_SAT) ? DRIVE_MAX : q[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/color_sensor_average_normalize.sv =====
// Top level: per-channel sliding-window averaging and clear-referenced normalization.
// One input beat is taken at a time: s_axis_tready is high only in the idle state. Each
// beat runs the four read-modify-write passes over the memory and then the shared
// 16-step divider three times, once per color; the divider is skipped when the clear mean is zero.
// Reset (rst, synchronous) clears the running sums, the write pointer and the fill flag;
// window entries not yet written since reset read as zero, so no clearing pass is needed.
`default_nettype none

module color_sensor_average_normalize
  import csan_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // red_pulse, green_pulse, blue_pulse, clear_pulse (20 bits each)
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // red_norm, green_norm, blue_norm, clear_level, red_drive, green_drive,
  // blue_drive, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // dark_flag
  output logic                       m_axis_tuser
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_EST   = 4'd2;
  localparam logic [3:0] ST_LVL   = 4'd3;
  localparam logic [3:0] ST_WR    = 4'd4;
  localparam logic [3:0] ST_DLOAD = 4'd5;
  localparam logic [3:0] ST_DSTEP = 4'd6;
  localparam logic [3:0] ST_SQ    = 4'd7;
  localparam logic [3:0] ST_DRV   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [CH_W-1:0] CH_LAST    = CH_W'(NUM_CH - 1);
  localparam logic [CH_W-1:0] COLOR_LAST = CH_W'(NUM_COLOR - 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NORM_W - 1);

  logic [3:0]         state;
  logic [CH_W-1:0]    ch;
  logic [PTR_W-1:0]   ptr;
  logic               filled;
  logic [PULSE_W-1:0] pulse [NUM_CH];
  sum_t               sum [NUM_CH];

  level_t             mem [MEM_DEPTH];
  level_t             rd_data;

  gap_t               gap;
  level_t             level_qe;
  level_t             level;
  level_t             old;

  norm_t              q_sh;
  level_t             rem;
  logic [CNT_W-1:0]   cnt;
  norm_t              norm [NUM_COLOR];
  logic [31:0]        prod;
  drive_t             drive [NUM_COLOR];

  norm_t              out_norm [NUM_COLOR];
  level_t             out_clear;
  drive_t             out_drive [NUM_COLOR];
  logic               out_dark;

  level_t             clear_mean;
  level_t             color_mean;
  logic               dark;
  logic [LEVEL_W:0]   trial;
  logic               take;
  norm_t              q_sh_next;
  level_t             rem_next;

  assign clear_mean = sum[CH_LAST][SUM_W-1:PTR_W];
  assign color_mean = sum[ch][SUM_W-1:PTR_W];
  assign dark       = (clear_mean == '0);

  assign trial     = {rem, q_sh[NORM_W-1]};
  assign take      = (trial >= {1'b0, clear_mean});
  assign q_sh_next = {q_sh[NORM_W-2:0], take};
  assign rem_next  = take ? LEVEL_W'(trial - {1'b0, clear_mean}) : trial[LEVEL_W-1:0];

  assign s_axis_tready = (state == ST_IDLE);

  // Window memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      rd_data <= mem[{ch, ptr}];
    end
    if (state == ST_WR) begin
      mem[{ch, ptr}] <= level;
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int i = 0; i < NUM_CH; i++) begin
        pulse[i] <= s_axis_tdata[i*PULSE_W +: PULSE_W];
      end
    end
    unique case (state)
      ST_RD: begin
        gap <= scaled_gap(pulse[ch]);
      end
      ST_EST: begin
        level_qe <= level_est(gap);
        // Until the window has filled, entries not yet written since reset count as zero.
        old      <= filled ? rd_data : '0;
      end
      ST_LVL: begin
        level <= level_fix(gap, level_qe);
      end
      ST_DLOAD: begin
        q_sh <= times255(color_mean);
        rem  <= '0;
        if (dark) begin
          norm[ch] <= NORM_MAX;
        end
      end
      ST_DSTEP: begin
        q_sh <= q_sh_next;
        rem  <= rem_next;
        if (cnt == CNT_LAST) begin
          norm[ch] <= q_sh_next;
        end
      end
      ST_SQ: begin
        prod <= {16'd0, norm[ch]} * {16'd0, norm[ch]};
      end
      ST_DRV: begin
        drive[ch] <= drive_of(prod);
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          for (int i = 0; i < NUM_COLOR; i++) begin
            out_norm[i]  <= norm[i];
            out_drive[i] <= drive[i];
          end
          out_clear <= clear_mean;
          out_dark  <= dark;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ch            <= '0;
      ptr           <= '0;
      filled        <= 1'b0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        sum[i] <= '0;
      end
    end else begin
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ch    <= '0;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_EST;
        end
        ST_EST: begin
          state <= ST_LVL;
        end
        ST_LVL: begin
          state <= ST_WR;
        end
        ST_WR: begin
          sum[ch] <= sum[ch] - sum_t'(old) + sum_t'(level);
          if (ch == CH_LAST) begin
            ch    <= '0;
            state <= ST_DLOAD;
            if (ptr == PTR_LAST) begin
              ptr    <= '0;
              filled <= 1'b1;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_RD;
          end
        end
        ST_DLOAD: begin
          cnt   <= '0;
          state <= dark ? ST_SQ : ST_DSTEP;
        end
        ST_DSTEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          state <= ST_DRV;
        end
        ST_DRV: begin
          if (ch == COLOR_LAST) begin
            ch    <= '0;
            state <= ST_OUT;
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_DLOAD;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {
    (OUT_DATA_W - OUT_USED_W)'(0),
    out_drive[2], out_drive[1], out_drive[0],
    out_clear,
    out_norm[2], out_norm[1], out_norm[0]
  };
  assign m_axis_tuser = out_dark;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DSTEP) |-> (rem < clear_mean))
    else $error("divider remainder not below clear mean");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |-> (level <= LEVEL_MAX))
    else $error("level out of range");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (sum[CH_LAST] <= sum_t'(WINDOW_DEPTH) * sum_t'(LEVEL_MAX)))
    else $error("clear window sum out of range");

  a_dark_saturates: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (out_norm[0] == NORM_MAX && out_drive[0] == DRIVE_MAX))
    else $error("dark result not saturated");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && state != ST_OUT) |=> !m_axis_tvalid)
    else $error("output beat repeated");

endmodule

`default_nettype wire

// ===== test/color_sensor_average_normalize_tb.sv =====
// Testbench for the color sensor window averaging and normalization block.
`timescale 1ns / 100ps

module color_sensor_average_normalize_tb;
  import csan_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 1150;
  localparam int MAX_REPORTS  = 40;

  localparam int RED   = 0;
  localparam int GREEN = 1;
  localparam int BLUE  = 2;
  localparam int CLEAR = 3;

  localparam int FULL_SCALE  = 255;
  localparam int LEVEL_SPAN  = 990;
  localparam int DIM_CLEAR   = 937;
  localparam int NUM_EDGES   = 9;

  typedef logic [PULSE_W-1:0] pulse_t;

  typedef enum int {MIX_BRIGHT, MIX_DARK, MIX_DIM, MIX_WIDE} mix_kind_t;

  typedef struct packed {
    norm_t  red_norm;
    norm_t  green_norm;
    norm_t  blue_norm;
    level_t clear_level;
    drive_t red_drive;
    drive_t green_drive;
    drive_t blue_drive;
    logic   dark;
  } reading_t;

  localparam pulse_t EDGE_PULSES [NUM_EDGES] = '{
    20'd0, 20'd9, 20'd10, 20'd999, 20'd1000, 20'd1001, 20'h55555, 20'hAAAAA, 20'hFFFFF
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // red_pulse, green_pulse, blue_pulse, clear_pulse (20 bits each)
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // red_norm, green_norm, blue_norm, clear_level, red_drive, green_drive,
  // blue_drive, zero fill
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  // dark_flag
  logic                   m_axis_tuser;

  level_t   light_window [NUM_CH][WINDOW_DEPTH];
  reading_t readings_due [$];
  int       mismatch_count = 0;
  int       burst_left = 0;
  int       cycle_count = 0;
  int       stall_mode = 0;
  int       stall_left = 0;

  color_sensor_average_normalize u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #CLK_HALF clk = ~clk;

  function automatic level_t pulse_level(pulse_t p);
    int span;
    span = (p > PULSE_CLAMP) ? 0 : int'(PULSE_CLAMP) - int'(p);
    return level_t'((span * FULL_SCALE) / LEVEL_SPAN);
  endfunction

  // Shift the new level into the channel's window and return the truncated mean.
  function automatic int window_mean(int ch, level_t lv);
    int sum;
    sum = 0;
    for (int i = 1; i < WINDOW_DEPTH; i++) light_window[ch][i-1] = light_window[ch][i];
    light_window[ch][WINDOW_DEPTH-1] = lv;
    for (int i = 0; i < WINDOW_DEPTH; i++) sum += light_window[ch][i];
    return sum / WINDOW_DEPTH;
  endfunction

  function automatic drive_t drive_level(int n);
    longint sq;
    sq = (longint'(n) * longint'(n)) / FULL_SCALE;
    return (sq > FULL_SCALE) ? drive_t'(FULL_SCALE) : drive_t'(sq);
  endfunction

  function automatic reading_t predict_reading(pulse_t red, pulse_t green, pulse_t blue,
                                               pulse_t clear);
    int       mean [NUM_CH];
    int       norm [NUM_COLOR];
    reading_t r;
    mean[RED]   = window_mean(RED, pulse_level(red));
    mean[GREEN] = window_mean(GREEN, pulse_level(green));
    mean[BLUE]  = window_mean(BLUE, pulse_level(blue));
    mean[CLEAR] = window_mean(CLEAR, pulse_level(clear));
    r.dark = (mean[CLEAR] == 0);
    for (int c = 0; c < NUM_COLOR; c++) begin
      if (r.dark) begin
        norm[c] = int'(NORM_MAX);
      end else begin
        norm[c] = (mean[c] * FULL_SCALE) / mean[CLEAR];
        if (norm[c] > int'(NORM_MAX)) norm[c] = int'(NORM_MAX);
      end
    end
    r.red_norm    = norm_t'(norm[RED]);
    r.green_norm  = norm_t'(norm[GREEN]);
    r.blue_norm   = norm_t'(norm[BLUE]);
    r.clear_level = level_t'(mean[CLEAR]);
    r.red_drive   = drive_level(norm[RED]);
    r.green_drive = drive_level(norm[GREEN]);
    r.blue_drive  = drive_level(norm[BLUE]);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Sends one beat; tvalid stays high inside a burst and drops only for a gap.
  task automatic send_pulses(pulse_t red, pulse_t green, pulse_t blue, pulse_t clear);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {clear, blue, green, red};
    do @(posedge clk); while (!s_axis_tready);
    readings_due.push_back(predict_reading(red, green, blue, clear));
  endtask

  function automatic pulse_t lit_pulse();
    if ($urandom_range(0, 7) == 0) return EDGE_PULSES[$urandom_range(0, 5)];
    return pulse_t'($urandom_range(0, 1050));
  endfunction

  // Starting from empty windows, the clear channel stays dark while the colors
  // fill up to full level; the last beat lifts the clear mean to one, which
  // drives the normalized colors to the ceiling without the dark flag.
  task automatic test_dark_and_ceiling();
    for (int k = 0; k < WINDOW_DEPTH - 1; k++) send_pulses('0, '0, '0, 20'hFFFFF);
    send_pulses('0, '0, '0, pulse_t'(DIM_CLEAR));
  endtask

  task automatic test_extremes();
    for (int k = 0; k < NUM_EDGES; k++)
      send_pulses(EDGE_PULSES[k], EDGE_PULSES[(k + 2) % NUM_EDGES],
                  EDGE_PULSES[(k + 5) % NUM_EDGES], EDGE_PULSES[(k + 7) % NUM_EDGES]);
  endtask

  task automatic test_random_mix();
    int        sent;
    int        run;
    int        pick;
    mix_kind_t kind;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 5) ? MIX_BRIGHT : (pick < 7) ? MIX_DARK : (pick < 8) ? MIX_DIM : MIX_WIDE;
      // A dark run must be at least as long as the window to empty the clear mean.
      run = (kind == MIX_DARK) ? $urandom_range(WINDOW_DEPTH + 4, 40) : $urandom_range(8, 40);
      for (int k = 0; k < run; k++) begin
        case (kind)
          MIX_BRIGHT: begin
            send_pulses(lit_pulse(), lit_pulse(), lit_pulse(), lit_pulse());
          end
          MIX_DARK: begin
            send_pulses(lit_pulse(), lit_pulse(), lit_pulse(),
                        pulse_t'($urandom_range(1000, 20'hFFFFF)));
          end
          MIX_DIM: begin
            send_pulses(pulse_t'($urandom_range(0, 300)), pulse_t'($urandom_range(0, 300)),
                        pulse_t'($urandom_range(0, 300)), pulse_t'($urandom_range(930, 1000)));
          end
          default: begin
            send_pulses(pulse_t'($urandom), pulse_t'($urandom), pulse_t'($urandom),
                        pulse_t'($urandom));
          end
        endcase
      end
      sent += run;
    end
  endtask

  // The receiver moves between steady, random, periodic and mostly stalled phases.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= (cycle_count % 5 == 0);
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (readings_due.size() == 0) begin
        report_mismatch("beat with no reading due", 1, 0);
      end else begin
        want = readings_due.pop_front();
        check_field("red_norm", m_axis_tdata[15:0], want.red_norm);
        check_field("green_norm", m_axis_tdata[31:16], want.green_norm);
        check_field("blue_norm", m_axis_tdata[47:32], want.blue_norm);
        check_field("clear_level", m_axis_tdata[56:48], want.clear_level);
        check_field("red_drive", m_axis_tdata[64:57], want.red_drive);
        check_field("green_drive", m_axis_tdata[72:65], want.green_drive);
        check_field("blue_drive", m_axis_tdata[80:73], want.blue_drive);
        check_field("dark_flag", m_axis_tuser, want.dark);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d readings outstanding", readings_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++)
      for (int i = 0; i < WINDOW_DEPTH; i++) light_window[c][i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_dark_and_ceiling();
    test_extremes();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && readings_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/csan_pkg.sv
src/color_sensor_average_normalize.sv
test/color_sensor_average_normalize_tb.sv
